### rtl/core/grc_pkg.sv
// Shared types, widths and constants of the grid ray caster.
`timescale 1ns / 1ps
`default_nettype none
package grc_pkg;

  localparam int unsigned DEF_SCREEN_COLUMNS = 128;
  localparam int unsigned DEF_VIEW_HEIGHT    = 48;

  // Divider sizes: dividend up to 2^32, divisor up to 65536.
  localparam int unsigned DIVD_W = 33;
  localparam int unsigned DVS_W  = 17;

  // Shared multiplier operand sizes.
  localparam int unsigned MUL_A_W = 33;
  localparam int unsigned MUL_B_W = 32;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_ANGLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_LO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_HI     = 3'd4;

  localparam logic [15:0] HALF_FOV = 16'd5461;
  localparam logic [15:0] MIN_DIST = 16'd410;

  localparam logic [31:0] C1 = 32'd1686629713;
  localparam logic [31:0] C3 = 32'd693598668;
  localparam logic [31:0] C5 = 32'd85569306;
  localparam logic [31:0] C7 = 32'd5026995;
  localparam logic [31:0] C9 = 32'd172272;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  // Horner coefficients after the leading C9 term.
  function automatic logic [31:0] poly_coef(input logic [1:0] k);
    logic [31:0] c;
    unique case (k)
      2'd0: c = C7;
      2'd1: c = C5;
      2'd2: c = C3;
      default: c = C1;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

### rtl/core/grc_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module grc_div
  import grc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int unsigned CNT_W = $clog2(DIVD_W);

  logic [DIVD_W-1:0] q_q;
  logic [DVS_W:0]    rem_q;
  logic [DVS_W-1:0]  dvs_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [DVS_W:0]    trial;
  logic              ge;

  assign trial = {rem_q[DVS_W-1:0], q_q[DIVD_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIVD_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      q_q   <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
      q_q   <= {q_q[DIVD_W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = q_q;

endmodule
`default_nettype wire

### rtl/core/grc_mul.sv
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none
module grc_mul
  import grc_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic [MUL_A_W-1:0] a_i,
  input  wire logic [MUL_B_W-1:0] b_i,
  output logic      [MUL_P_W-1:0] prod_o
);

  always_ff @(posedge clk_i) begin
    prod_o <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
  end

endmodule
`default_nettype wire

### rtl/core/grid_raycast_column_top.sv
// Top level of the wall-column ray caster with its sequencer and walk datapath.
//
//   Channel   Signals                                   Direction
//   input     in_valid_i, in_stall_o, column_i          item in
//   output    out_valid_o, out_stall_i, result fields   item out
//   config    cfg_valid_i, cfg_ready_o, cfg_index_i/data  register writes
//
// The angle offset comes from a constant reciprocal multiply. The two sines
// each use the shared multiplier. Each nonzero ray component needs one pass of
// the divider for its step length, followed by the side-distance setup, and a
// zero component skips the divider. The grid walk takes one cycle per cell (at
// most 16), and a hit adds one more divider pass for the slice height. Reset
// clears the sequencer and loads the default view and map. The input stalls
// while an item is in flight, and a finished result waits only while the output
// register still holds one that is stalled.
`timescale 1ns / 1ps
`default_nettype none
module grid_raycast_column_top
  import grc_pkg::*;
#(
  parameter int unsigned SCREEN_COLUMNS = DEF_SCREEN_COLUMNS,
  parameter int unsigned VIEW_HEIGHT    = DEF_VIEW_HEIGHT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [6:0]           column_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic      [6:0]           column_out_o,
  output logic                      hit_o,
  output logic                      side_o,
  output logic      [15:0]          wall_distance_o,
  output logic      [5:0]           draw_start_o,
  output logic      [5:0]           draw_end_o,
  output logic      [2:0]           shade_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [63:0]          cfg_data_i
);

  // The angle offset column*65536/(6*SCREEN_COLUMNS) is formed by a reciprocal
  // multiply, which is exact for every 7-bit column.
  localparam longint unsigned OFFS_DEN = 64'(6 * SCREEN_COLUMNS);
  localparam logic [28:0] OFFS_RCP = 29'(((64'd1 << 35) + OFFS_DEN - 1) / OFFS_DEN);
  // Constant operands of the divider.
  localparam logic [DIVD_W-1:0] LH_NUM   = DIVD_W'(VIEW_HEIGHT * 4096);
  localparam logic [DIVD_W-1:0] ONE_Q32  = DIVD_W'(1) << 32;
  localparam logic signed [13:0] VH_S    = 14'(VIEW_HEIGHT);
  localparam int unsigned SD_W = 58;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_OFFS  = 4'd1;
  localparam logic [3:0] S_SQ    = 4'd2;
  localparam logic [3:0] S_T2    = 4'd3;
  localparam logic [3:0] S_POLY  = 4'd4;
  localparam logic [3:0] S_POLYU = 4'd5;
  localparam logic [3:0] S_FIN   = 4'd6;
  localparam logic [3:0] S_FINU  = 4'd7;
  localparam logic [3:0] S_DLT   = 4'd8;
  localparam logic [3:0] S_DLTW  = 4'd9;
  localparam logic [3:0] S_SDM   = 4'd10;
  localparam logic [3:0] S_SDU   = 4'd11;
  localparam logic [3:0] S_WALK  = 4'd12;
  localparam logic [3:0] S_LH    = 4'd13;
  localparam logic [3:0] S_LHW   = 4'd14;
  localparam logic [3:0] S_OUT   = 4'd15;

  // Configuration registers.
  logic [14:0]  pos_x_q, pos_y_q;
  logic [15:0]  view_angle_q;
  logic [127:0] map_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q      <= 15'd6144;
      pos_y_q      <= 15'd6144;
      view_angle_q <= 16'd0;
      map_q        <= {64'd6148891240493563905, 64'd4612046801049048405};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POS_X:      pos_x_q        <= cfg_data_i[14:0];
        CFG_POS_Y:      pos_y_q        <= cfg_data_i[14:0];
        CFG_VIEW_ANGLE: view_angle_q   <= cfg_data_i[15:0];
        CFG_MAP_LO:     map_q[63:0]    <= cfg_data_i;
        CFG_MAP_HI:     map_q[127:64]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sequencer and working registers.
  logic [3:0]  state_q;
  logic [6:0]  col_q;
  logic [15:0] ang_q;
  logic        sel_q, ax_q;
  logic [1:0]  quad_q, k_q;
  logic [14:0] r_q;
  logic [30:0] t2_q;
  logic [31:0] p_q;
  logic signed [17:0] dx_q, dy_q;
  logic [40:0] dd_q, ddx_q, ddy_q;
  logic [SD_W-1:0] sdx_q, sdy_q, perp_q;
  logic signed [4:0] mx_q, my_q;
  logic [3:0]  i_q;
  logic [1:0]  type_q;
  logic        side_q;
  logic [15:0] dist_q;
  logic        res_hit_q, res_side_q;
  logic [15:0] res_dist_q;
  logic [5:0]  res_ds_q, res_de_q;
  logic [2:0]  res_shade_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;

  grc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  grc_mul u_mul (.clk_i, .a_i(mul_a), .b_i(mul_b), .prod_o(prod));

  logic accept;
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  // Sine argument t = r << 16.
  logic [30:0] t_val;
  assign t_val = {r_q, 16'd0};

  // Sine finishing: round from Q30 to Q16, clamp at one, fold the sign.
  logic [34:0] s_q30;
  logic [20:0] s_rnd;
  logic [16:0] s_mag;
  logic signed [17:0] s_val;
  assign s_q30 = prod[64:30];
  assign s_rnd = 21'((s_q30 + 35'd8192) >> 14);
  assign s_mag = (s_rnd > 21'd65536) ? 17'd65536 : s_rnd[16:0];
  assign s_val = quad_q[1] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});

  // Current axis of the step-length setup.
  logic signed [17:0] d_cur;
  logic        d_neg;
  logic [16:0] d_mag;
  logic [11:0] f_cur;
  logic [12:0] edge_dist;
  assign d_cur     = ax_q ? dy_q : dx_q;
  assign d_neg     = d_cur[17];
  assign d_mag     = d_neg ? 17'(-d_cur) : d_cur[16:0];
  assign f_cur     = ax_q ? pos_y_q[11:0] : pos_x_q[11:0];
  assign edge_dist = d_neg ? {1'b0, f_cur} : (13'd4096 - {1'b0, f_cur});

  logic [SD_W-1:0] sd_init;
  assign sd_init = dd_q[40] ? (SD_W'(edge_dist) << 40) : prod[SD_W-1:0];

  // One step of the grid walk; ties step in y.
  logic step_x;
  logic signed [4:0] nmx, nmy;
  logic leave;
  logic [5:0] cell_idx;
  logic [1:0] cell_type;
  assign step_x    = sdx_q < sdy_q;
  assign nmx       = step_x ? (mx_q + (dx_q[17] ? -5'sd1 : 5'sd1)) : mx_q;
  assign nmy       = step_x ? my_q : (my_q + (dy_q[17] ? -5'sd1 : 5'sd1));
  assign leave     = (nmx[4:3] != 2'b00) || (nmy[4:3] != 2'b00);
  assign cell_idx  = {nmx[2:0], nmy[2:0]};
  assign cell_type = map_q[{cell_idx, 1'b0} +: 2];

  // Perpendicular distance, clamped to the valid range.
  logic [SD_W-17:0] d_raw;
  logic [15:0] d_clamp;
  assign d_raw   = perp_q[SD_W-1:16];
  assign d_clamp = (d_raw < (SD_W-16)'(MIN_DIST)) ? MIN_DIST :
                   (d_raw > (SD_W-16)'(16'hFFFF)) ? 16'hFFFF : d_raw[15:0];

  // Slice extent from the line height.
  logic signed [13:0] lh, diff, s_un, e_un;
  assign lh   = $signed({1'b0, div_rsp.quotient[12:0]});
  assign diff = VH_S - lh;
  assign s_un = diff[13] ? ((diff + 14'sd1) >>> 1) : (diff >>> 1);
  assign e_un = s_un + lh;

  // Shared multiplier operand selection.
  always_comb begin
    unique case (state_q)
      S_POLY: begin
        mul_a = MUL_A_W'(p_q);
        mul_b = MUL_B_W'(t2_q);
      end
      S_FIN: begin
        mul_a = MUL_A_W'(t_val);
        mul_b = p_q;
      end
      S_SDM: begin
        mul_a = dd_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(edge_dist);
      end
      default: begin
        mul_a = MUL_A_W'(t_val);
        mul_b = MUL_B_W'(t_val);
      end
    endcase
  end

  // Divider requests.
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = '0;
    priority if (state_q == S_DLT && d_mag != 17'd0) begin
      div_req.start    = 1'b1;
      div_req.dividend = ONE_Q32;
      div_req.divisor  = d_mag;
    end else if (state_q == S_LH) begin
      div_req.start    = 1'b1;
      div_req.dividend = LH_NUM;
      div_req.divisor  = DVS_W'(d_clamp);
    end else begin
      div_req.start = 1'b0;
    end
  end

  logic [34:0] offs_prod;
  logic [15:0] ang_new;
  assign offs_prod = 35'(col_q) * 35'(OFFS_RCP);
  assign ang_new   = view_angle_q - HALF_FOV + offs_prod[34:19];

  logic out_free;
  assign out_free = !out_valid_o || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      unique case (state_q)
        S_IDLE:  if (accept) state_q <= S_OFFS;
        S_OFFS:  state_q <= S_SQ;
        S_SQ:    state_q <= S_T2;
        S_T2:    state_q <= S_POLY;
        S_POLY:  state_q <= S_POLYU;
        S_POLYU: state_q <= (k_q == 2'd3) ? S_FIN : S_POLY;
        S_FIN:   state_q <= S_FINU;
        S_FINU:  state_q <= sel_q ? S_DLT : S_SQ;
        S_DLT:   state_q <= (d_mag == 17'd0) ? S_SDM : S_DLTW;
        S_DLTW:  if (div_rsp.done) state_q <= S_SDM;
        S_SDM:   state_q <= S_SDU;
        S_SDU:   state_q <= ax_q ? S_WALK : S_DLT;
        S_WALK: begin
          if (leave) state_q <= S_OUT;
          else if (cell_type != 2'd0) state_q <= S_LH;
          else if (i_q == 4'd15) state_q <= S_OUT;
        end
        S_LH:    state_q <= S_LHW;
        S_LHW:   if (div_rsp.done) state_q <= S_OUT;
        S_OUT:   if (out_free) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: if (accept) col_q <= column_i;
      S_OFFS: begin
        ang_q  <= ang_new;
        sel_q  <= 1'b0;
        quad_q <= ang_new[15:14] + 2'd1;
        r_q    <= ang_new[14] ? {1'b0, ang_new[13:0]}
                              : 15'(15'd16384 - {1'b0, ang_new[13:0]});
      end
      S_T2: begin
        t2_q <= prod[60:30];
        p_q  <= C9;
        k_q  <= 2'd0;
      end
      S_POLYU: begin
        p_q <= poly_coef(k_q) - prod[61:30];
        k_q <= k_q + 2'd1;
      end
      S_FINU: begin
        if (!sel_q) begin
          dx_q   <= s_val;
          sel_q  <= 1'b1;
          quad_q <= ang_q[15:14];
          r_q    <= ang_q[14] ? 15'(15'd16384 - {1'b0, ang_q[13:0]})
                              : {1'b0, ang_q[13:0]};
        end else begin
          dy_q <= s_val;
          ax_q <= 1'b0;
        end
      end
      S_DLT: if (d_mag == 17'd0) dd_q <= 41'd1 << 40;
      S_DLTW: if (div_rsp.done) dd_q <= 41'(div_rsp.quotient);
      S_SDU: begin
        if (!ax_q) begin
          sdx_q <= sd_init;
          ddx_q <= dd_q;
          ax_q  <= 1'b1;
        end else begin
          sdy_q <= sd_init;
          ddy_q <= dd_q;
          mx_q  <= {2'b00, pos_x_q[14:12]};
          my_q  <= {2'b00, pos_y_q[14:12]};
          i_q   <= 4'd0;
        end
      end
      S_WALK: begin
        i_q    <= i_q + 4'd1;
        mx_q   <= nmx;
        my_q   <= nmy;
        type_q <= cell_type;
        side_q <= !step_x;
        if (step_x) begin
          perp_q <= sdx_q;
          sdx_q  <= sdx_q + (SD_W'(ddx_q) << 12);
        end else begin
          perp_q <= sdy_q;
          sdy_q  <= sdy_q + (SD_W'(ddy_q) << 12);
        end
        if (leave || (cell_type == 2'd0 && i_q == 4'd15)) begin
          res_hit_q   <= 1'b0;
          res_side_q  <= 1'b0;
          res_dist_q  <= 16'd0;
          res_ds_q    <= 6'd0;
          res_de_q    <= 6'd0;
          res_shade_q <= 3'd0;
        end
      end
      S_LH: dist_q <= d_clamp;
      S_LHW: begin
        if (div_rsp.done) begin
          res_hit_q   <= 1'b1;
          res_side_q  <= side_q;
          res_dist_q  <= dist_q;
          res_ds_q    <= s_un[13] ? 6'd0 : s_un[5:0];
          res_de_q    <= (e_un >= VH_S) ? 6'(VIEW_HEIGHT - 1) : e_un[5:0];
          res_shade_q <= (type_q == 2'd2) ? (side_q ? 3'd6 : 3'd3)
                                          : (side_q ? 3'd4 : 3'd2);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) begin
      column_out_o    <= col_q;
      hit_o           <= res_hit_q;
      side_o          <= res_side_q;
      wall_distance_o <= res_dist_q;
      draw_start_o    <= res_ds_q;
      draw_end_o      <= res_de_q;
      shade_o         <= res_shade_q;
    end
  end

endmodule
`default_nettype wire
